FILE: rtl/core/mel_pkg.sv
// Shared types, phase codes and name tables for the mail envelope line matcher.
package mel_pkg;

	// Default longest line position that is tracked before the counter saturates.
	localparam int unsigned MAX_LINE_DEF = 1024;

	// Widths fixed by the request and result fields.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned OFFS_W = 10;
	localparam int unsigned TOKL_W = 3;
	localparam int unsigned TOKC_W = 24;

	// Character constants.
	localparam logic [BYTE_W-1:0] CH_ESCAPE = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_UPPER_F = 8'h46;

	// The leader text "From ", first character at index 0.
	localparam int unsigned LEADER_LEN = 5;
	localparam logic [LEADER_LEN-1:0][BYTE_W-1:0] LEADER_TEXT = {" ", "m", "o", "r", "F"};

	// Weekday and month names in lower case, packed three characters to a word.
	localparam logic [6:0][TOKC_W-1:0] DAY_NAMES =
		{"sat", "fri", "thu", "wed", "tue", "mon", "sun"};
	localparam logic [11:0][TOKC_W-1:0] MONTH_NAMES =
		{"dec", "nov", "oct", "sep", "aug", "jul", "jun", "may", "apr", "mar", "feb", "jan"};

	// Parse phases of one line.
	typedef enum logic [3:0] {
		PH_FIRST, PH_LEADER, PH_WHITE, PH_ADDR,
		PH_DAY_WS, PH_DAY, PH_MON_WS, PH_MON,
		PH_NUM_WS, PH_NUM, PH_TIME_WS, PH_TIME, PH_TAIL
	} phase_t;

	// One request: a character and the last-byte mark.
	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              line_end;
	} req_t;

	// One result: the match flag and the address offset.
	typedef struct packed {
		logic              is_envelope;
		logic [OFFS_W-1:0] address_offset;
	} res_t;

	function automatic logic is_white(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// ASCII upper case letters fold to lower case.
	function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
	endfunction

	function automatic logic day_match(input logic [TOKC_W-1:0] t);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 7; i++) begin
			hit = hit | (DAY_NAMES[i] == t);
		end
		return hit;
	endfunction

	function automatic logic month_match(input logic [TOKC_W-1:0] t);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 12; i++) begin
			hit = hit | (MONTH_NAMES[i] == t);
		end
		return hit;
	endfunction

endpackage

FILE: rtl/core/mail_envelope_line_matcher.sv
// Top level of the mail envelope line matcher: request register, parser, result register.
//
// A text line enters on the up channel one byte per request, with line_end set on
// its final byte. The block checks the line against the mailbox envelope form
// ("From " line with address, weekday, month, day, time) and gives one result on
// the dn channel for each line, taken from the request that carried line_end.
// Bytes without line_end produce no result.
//
// Throughput is one byte per cycle while up_ready is high: each byte needs a single phase
// update of the line state, done combinationally between the request register and the
// result register. dn_valid rises when the last byte moves on into the result register.
//
// When the receiver stalls, the pending result holds in the result register;
// bytes that do not end a line keep flowing, and a further last byte waits in
// the request register, which then drops up_ready until the result is taken.
//
// Reset clears the line state to the start of a line and empties both registers.
module mail_envelope_line_matcher #(
	parameter int unsigned MAX_LINE = mel_pkg::MAX_LINE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  mel_pkg::req_t up_data,
	output logic          dn_valid,
	input  logic          dn_ready,
	output mel_pkg::res_t dn_data
);

	logic          valid_s1;
	mel_pkg::req_t req_s1;
	logic          dn_valid_q;
	mel_pkg::res_t dn_data_q;
	mel_pkg::res_t res_c;
	logic          proceed;

	// A byte leaves the request register unless it ends a line and the result is blocked.
	assign proceed  = valid_s1 && (!req_s1.line_end || !dn_valid_q || dn_ready);
	assign up_ready = !valid_s1 || proceed;

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			req_s1 <= up_data;
		end
	end

	mel_parse #(
		.MAX_LINE(MAX_LINE)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (proceed),
		.req    (req_s1),
		.res    (res_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid_q <= 1'b0;
		end else if (proceed && req_s1.line_end) begin
			dn_valid_q <= 1'b1;
		end else if (dn_ready) begin
			dn_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && req_s1.line_end) begin
			dn_data_q <= res_c;
		end
	end

	assign dn_valid = dn_valid_q;
	assign dn_data  = dn_data_q;

	// A line that is not an envelope reports offset zero.
	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid_q && !dn_data_q.is_envelope |-> dn_data_q.address_offset == '0)
		else $error("non-envelope result carries an address offset");

	// Only a held line end in the request register can stop the up channel.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!up_ready |-> valid_s1 && req_s1.line_end && dn_valid_q && !dn_ready)
		else $error("up channel stalled without a blocked result");

	// A line end that moves on always shows up as a result next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		proceed && req_s1.line_end |=> dn_valid_q)
		else $error("line end produced no result");

	// A waiting result is never overwritten.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid_q && !dn_ready |=> dn_valid_q && $stable(dn_data_q))
		else $error("pending result lost or changed");

endmodule

FILE: rtl/core/mel_parse.sv
// Line state and per-byte parse step of the envelope matcher.
module mel_parse #(
	parameter int unsigned MAX_LINE = mel_pkg::MAX_LINE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  mel_pkg::req_t  req,
	output mel_pkg::res_t  res
);

	localparam int unsigned POS_W  = $clog2(MAX_LINE + 1);
	localparam int unsigned ADDR_W = $clog2(MAX_LINE);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

	mel_pkg::phase_t                 phase_q, phase_d;
	logic [POS_W-1:0]                pos_q, pos_d;
	logic [mel_pkg::TOKL_W-1:0]      tokl_q, tokl_d;
	logic [mel_pkg::TOKC_W-1:0]      tokc_q, tokc_d;
	logic [ADDR_W-1:0]               addr_q, addr_d;
	logic                            colon_q, colon_d;
	logic                            rej_q, rej_d;
	logic                            esc_q, esc_d;

	logic [mel_pkg::BYTE_W-1:0] c;
	logic                       c_white;
	logic                       c_digit;
	logic                       match;

	assign c       = req.text_byte;
	assign c_white = mel_pkg::is_white(c);
	assign c_digit = mel_pkg::is_digit(c);

	// One parse step on the current byte; a rejected line ignores its bytes.
	always_comb begin
		phase_d = phase_q;
		tokl_d  = tokl_q;
		tokc_d  = tokc_q;
		addr_d  = addr_q;
		colon_d = colon_q;
		rej_d   = rej_q;
		esc_d   = esc_q;
		if (!rej_q) begin
			unique case (phase_q)
				mel_pkg::PH_FIRST: begin
					if (c == mel_pkg::CH_ESCAPE) begin
						esc_d   = 1'b1;
						tokl_d  = '0;
						phase_d = mel_pkg::PH_LEADER;
					end else if (c == mel_pkg::CH_UPPER_F) begin
						tokl_d  = mel_pkg::TOKL_W'(1);
						phase_d = mel_pkg::PH_LEADER;
					end else begin
						rej_d = 1'b1;
					end
				end
				mel_pkg::PH_LEADER: begin
					if (tokl_q >= mel_pkg::TOKL_W'(mel_pkg::LEADER_LEN) ||
						c != mel_pkg::LEADER_TEXT[tokl_q]) begin
						rej_d = 1'b1;
					end else begin
						tokl_d = tokl_q + mel_pkg::TOKL_W'(1);
						if (tokl_q == mel_pkg::TOKL_W'(mel_pkg::LEADER_LEN - 1)) begin
							phase_d = mel_pkg::PH_WHITE;
						end
					end
				end
				mel_pkg::PH_WHITE: begin
					if (!c_white) begin
						if (c == mel_pkg::CH_COLON || pos_q == POS_MAX) begin
							rej_d = 1'b1;
						end else begin
							addr_d  = pos_q[ADDR_W-1:0];
							phase_d = mel_pkg::PH_ADDR;
						end
					end
				end
				mel_pkg::PH_ADDR: begin
					if (c_white) begin
						phase_d = mel_pkg::PH_DAY_WS;
					end
				end
				mel_pkg::PH_DAY_WS, mel_pkg::PH_MON_WS: begin
					if (!c_white) begin
						tokl_d  = mel_pkg::TOKL_W'(1);
						tokc_d  = mel_pkg::TOKC_W'(mel_pkg::fold(c));
						phase_d = (phase_q == mel_pkg::PH_DAY_WS) ?
							mel_pkg::PH_DAY : mel_pkg::PH_MON;
					end
				end
				mel_pkg::PH_DAY, mel_pkg::PH_MON: begin
					if (c_white) begin
						if (tokl_q != mel_pkg::TOKL_W'(3) ||
							!((phase_q == mel_pkg::PH_DAY) ? mel_pkg::day_match(tokc_q) :
								mel_pkg::month_match(tokc_q))) begin
							rej_d = 1'b1;
						end else begin
							phase_d = (phase_q == mel_pkg::PH_DAY) ?
								mel_pkg::PH_MON_WS : mel_pkg::PH_NUM_WS;
						end
					end else if (tokl_q >= mel_pkg::TOKL_W'(3)) begin
						rej_d = 1'b1;
					end else begin
						tokl_d = tokl_q + mel_pkg::TOKL_W'(1);
						tokc_d = {tokc_q[mel_pkg::TOKC_W-mel_pkg::BYTE_W-1:0], mel_pkg::fold(c)};
					end
				end
				mel_pkg::PH_NUM_WS, mel_pkg::PH_TIME_WS: begin
					if (!c_white) begin
						if (!c_digit) begin
							rej_d = 1'b1;
						end else begin
							tokl_d  = mel_pkg::TOKL_W'(1);
							phase_d = (phase_q == mel_pkg::PH_NUM_WS) ?
								mel_pkg::PH_NUM : mel_pkg::PH_TIME;
						end
					end
				end
				mel_pkg::PH_NUM: begin
					if (c_white) begin
						phase_d = mel_pkg::PH_TIME_WS;
					end else if (!c_digit || tokl_q >= mel_pkg::TOKL_W'(2)) begin
						rej_d = 1'b1;
					end else begin
						tokl_d = tokl_q + mel_pkg::TOKL_W'(1);
					end
				end
				mel_pkg::PH_TIME: begin
					if (c_white) begin
						if (tokl_q < mel_pkg::TOKL_W'(4)) begin
							rej_d = 1'b1;
						end else begin
							phase_d = mel_pkg::PH_TAIL;
						end
					end else begin
						// The length only matters up to four, so it saturates.
						if (tokl_q != '1) begin
							tokl_d = tokl_q + mel_pkg::TOKL_W'(1);
						end
						if (c == mel_pkg::CH_COLON) begin
							colon_d = 1'b1;
						end
					end
				end
				mel_pkg::PH_TAIL: begin
					if (c == mel_pkg::CH_COLON) begin
						colon_d = 1'b1;
					end
				end
				default: begin
					rej_d = 1'b1;
				end
			endcase
		end
	end

	// Byte position counts up to the line limit and stays there.
	always_comb begin
		pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
	end

	// Verdict taken from the state after this byte.
	always_comb begin
		match = !rej_d && colon_d &&
			((phase_d == mel_pkg::PH_TIME && tokl_d >= mel_pkg::TOKL_W'(4)) ||
			 phase_d == mel_pkg::PH_TAIL);
		res.is_envelope    = match;
		res.address_offset = match ? mel_pkg::OFFS_W'(addr_d) : '0;
	end

	// Line state; the last byte returns everything to the line start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mel_pkg::PH_FIRST;
			pos_q   <= '0;
			tokl_q  <= '0;
			tokc_q  <= '0;
			addr_q  <= '0;
			colon_q <= 1'b0;
			rej_q   <= 1'b0;
			esc_q   <= 1'b0;
		end else if (step) begin
			if (req.line_end) begin
				phase_q <= mel_pkg::PH_FIRST;
				pos_q   <= '0;
				tokl_q  <= '0;
				tokc_q  <= '0;
				addr_q  <= '0;
				colon_q <= 1'b0;
				rej_q   <= 1'b0;
				esc_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				tokl_q  <= tokl_d;
				tokc_q  <= tokc_d;
				addr_q  <= addr_d;
				colon_q <= colon_d;
				rej_q   <= rej_d;
				esc_q   <= esc_d;
			end
		end
	end

endmodule

FILE: dv/mail_envelope_line_matcher_tb.sv
// Self-checking testbench for the mailbox envelope line matcher, with its own line parser.
module mail_envelope_line_matcher_tb;

	localparam int unsigned LINE_CAP = mel_pkg::MAX_LINE_DEF;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned ITEM_TARGET = 1450;
	localparam int unsigned RANDOM_LINES = 16;
	localparam logic [39:0] FROM_WORD = "From ";
	localparam string WEEKDAYS = "sunmontuewedthufrisat";
	localparam string MONTHS = "janfebmaraprmayjunjulaugsepoctnovdec";

	// One byte waiting to be sent, with the idle cycles before it.
	typedef struct {
		mel_pkg::req_t req;
		int unsigned   gap;
		bit            drain_first;
	} byte_slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic up_valid = 1'b0;
	logic up_ready;
	mel_pkg::req_t up_data = '0;
	logic dn_valid;
	logic dn_ready = 1'b0;
	mel_pkg::res_t dn_data;

	byte_slot_t     pending[$];
	logic [7:0]     line_buf[$];
	mel_pkg::res_t  verdicts_due[$];
	int unsigned total_bytes;
	int unsigned bytes_sent;
	int unsigned idle_count;
	int unsigned verdicts_seen;
	int unsigned hold_left;
	int unsigned calm_left;
	int unsigned quiet;
	int unsigned errors;

	// Parser state of the line being predicted.
	mel_pkg::phase_t ph;
	logic [10:0] pos;
	logic [2:0]  tok_len;
	logic [23:0] tok;
	logic [9:0]  addr_at;
	logic        colon_hit;
	logic        dead;
	logic        escaped;

	mail_envelope_line_matcher #(.MAX_LINE(LINE_CAP)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(up_valid),
		.up_ready(up_ready),
		.up_data (up_data),
		.dn_valid(dn_valid),
		.dn_ready(dn_ready),
		.dn_data (dn_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic is_blank(input logic [7:0] c);
		return (c == mel_pkg::CH_SPACE) || (c == mel_pkg::CH_TAB);
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
	endfunction

	function automatic logic weekday_known(input logic [23:0] t);
		case (t)
			"sun", "mon", "tue", "wed", "thu", "fri", "sat": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic month_known(input logic [23:0] t);
		case (t)
			"jan", "feb", "mar", "apr", "may", "jun",
			"jul", "aug", "sep", "oct", "nov", "dec": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void line_restart();
		ph = mel_pkg::PH_FIRST;
		pos = '0;
		tok_len = '0;
		tok = '0;
		addr_at = '0;
		colon_hit = 1'b0;
		dead = 1'b0;
		escaped = 1'b0;
	endfunction

	// Moves the parser over one character of a line that is still alive.
	function automatic void advance_parser(input logic [7:0] c);
		logic ok;
		case (ph)
			mel_pkg::PH_FIRST: begin
				if (c == mel_pkg::CH_ESCAPE) begin
					escaped = 1'b1;
					tok_len = '0;
					ph = mel_pkg::PH_LEADER;
				end else if (c == mel_pkg::CH_UPPER_F) begin
					tok_len = 3'd1;
					ph = mel_pkg::PH_LEADER;
				end else begin
					dead = 1'b1;
				end
			end
			mel_pkg::PH_LEADER: begin
				if (tok_len >= 3'd5 || c != FROM_WORD[39 - 8*tok_len -: 8]) begin
					dead = 1'b1;
				end else begin
					tok_len = tok_len + 3'd1;
					if (tok_len == 3'd5) ph = mel_pkg::PH_WHITE;
				end
			end
			mel_pkg::PH_WHITE: begin
				if (!is_blank(c)) begin
					if (c == mel_pkg::CH_COLON || pos >= LINE_CAP) begin
						dead = 1'b1;
					end else begin
						addr_at = pos[9:0];
						ph = mel_pkg::PH_ADDR;
					end
				end
			end
			mel_pkg::PH_ADDR: begin
				if (is_blank(c)) ph = mel_pkg::PH_DAY_WS;
			end
			mel_pkg::PH_DAY_WS, mel_pkg::PH_MON_WS: begin
				if (!is_blank(c)) begin
					tok_len = 3'd1;
					tok = {16'h0, to_lower(c)};
					ph = (ph == mel_pkg::PH_DAY_WS) ? mel_pkg::PH_DAY : mel_pkg::PH_MON;
				end
			end
			mel_pkg::PH_DAY, mel_pkg::PH_MON: begin
				if (is_blank(c)) begin
					ok = (tok_len == 3'd3) &&
						((ph == mel_pkg::PH_DAY) ? weekday_known(tok) : month_known(tok));
					if (!ok) dead = 1'b1;
					else ph = (ph == mel_pkg::PH_DAY) ? mel_pkg::PH_MON_WS : mel_pkg::PH_NUM_WS;
				end else if (tok_len >= 3'd3) begin
					dead = 1'b1;
				end else begin
					tok_len = tok_len + 3'd1;
					tok = {tok[15:0], to_lower(c)};
				end
			end
			mel_pkg::PH_NUM_WS, mel_pkg::PH_TIME_WS: begin
				if (!is_blank(c)) begin
					if (!is_numeral(c)) begin
						dead = 1'b1;
					end else begin
						tok_len = 3'd1;
						ph = (ph == mel_pkg::PH_NUM_WS) ? mel_pkg::PH_NUM : mel_pkg::PH_TIME;
					end
				end
			end
			mel_pkg::PH_NUM: begin
				if (is_blank(c)) ph = mel_pkg::PH_TIME_WS;
				else if (!is_numeral(c) || tok_len >= 3'd2) dead = 1'b1;
				else tok_len = tok_len + 3'd1;
			end
			mel_pkg::PH_TIME: begin
				if (is_blank(c)) begin
					if (tok_len < 3'd4) dead = 1'b1;
					else ph = mel_pkg::PH_TAIL;
				end else begin
					if (tok_len < 3'd7) tok_len = tok_len + 3'd1;
					if (c == mel_pkg::CH_COLON) colon_hit = 1'b1;
				end
			end
			mel_pkg::PH_TAIL: begin
				if (c == mel_pkg::CH_COLON) colon_hit = 1'b1;
			end
			default: dead = 1'b1;
		endcase
	endfunction

	// Predicts the effect of one accepted request; a line end yields one verdict.
	function automatic void envelope_predict(input mel_pkg::req_t r);
		mel_pkg::res_t v;
		logic hit;
		if (!dead) advance_parser(r.text_byte);
		if (!r.line_end) begin
			if (pos < LINE_CAP) pos = pos + 11'd1;
		end else begin
			hit = !dead && colon_hit &&
				((ph == mel_pkg::PH_TIME && tok_len >= 3'd4) || ph == mel_pkg::PH_TAIL);
			v.is_envelope = hit;
			v.address_offset = hit ? addr_at : '0;
			verdicts_due.push_back(v);
			line_restart();
		end
	endfunction

	// Idle length before a byte: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_byte(input logic [7:0] c);
		line_buf.push_back(c);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	function automatic void push_blanks(input int unsigned lo, input int unsigned hi);
		int unsigned n;
		n = $urandom_range(lo, hi);
		repeat (n) line_buf.push_back($urandom_range(0, 1) ? mel_pkg::CH_SPACE : mel_pkg::CH_TAB);
	endfunction

	// Pushes a letter in upper or lower case at random.
	function automatic void push_letter(input logic [7:0] c);
		logic [7:0] k;
		k = c;
		if (k >= "a" && k <= "z" && $urandom_range(0, 1) == 1) k = k - 8'd32;
		line_buf.push_back(k);
	endfunction

	function automatic logic [7:0] random_solid(input bit allow_colon);
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (is_blank(c) || (!allow_colon && c == mel_pkg::CH_COLON));
		return c;
	endfunction

	// A weekday or month name from the list, or now and then a random word.
	function automatic void push_name(input string names, input int unsigned count);
		int unsigned k;
		int unsigned n;
		k = $urandom_range(0, count - 1);
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) push_letter(8'(8'h61 + $urandom_range(0, 25)));
		end else begin
			for (int i = 0; i < 3; i++) push_letter(names[3*k + i]);
		end
	endfunction

	// Moves the buffered line into the send queue, line_end on its last byte.
	function automatic void close_line(input bit drain_first);
		byte_slot_t s;
		bit calm;
		calm = ($urandom_range(0, 3) == 0);
		foreach (line_buf[i]) begin
			s.req.text_byte = line_buf[i];
			s.req.line_end = (i == line_buf.size() - 1);
			s.gap = calm ? 0 : pick_gap();
			s.drain_first = drain_first && (i == 0);
			pending.push_back(s);
		end
		line_buf.delete();
	endfunction

	// A line of the envelope form with random content, sometimes damaged.
	function automatic void random_envelope();
		int unsigned n;
		int unsigned k;
		if ($urandom_range(0, 3) == 0) push_byte(mel_pkg::CH_ESCAPE);
		push_text("From ");
		push_blanks(0, 2);
		n = $urandom_range(1, 10);
		push_byte(random_solid($urandom_range(0, 19) == 0));
		for (int i = 1; i < n; i++) push_byte(random_solid(1'b1));
		push_blanks(1, 3);
		push_name(WEEKDAYS, 7);
		push_blanks(1, 3);
		push_name(MONTHS, 12);
		push_blanks(1, 3);
		n = ($urandom_range(0, 14) == 0) ? 3 : $urandom_range(1, 2);
		repeat (n) push_byte(8'(8'h30 + $urandom_range(0, 9)));
		push_blanks(1, 3);
		push_byte(($urandom_range(0, 14) == 0) ? random_solid(1'b1) :
			8'(8'h30 + $urandom_range(0, 9)));
		n = $urandom_range(1, 7);
		repeat (n) push_byte(($urandom_range(0, 3) == 0) ? mel_pkg::CH_COLON :
			8'(8'h30 + $urandom_range(0, 9)));
		if ($urandom_range(0, 1) == 1) begin
			push_blanks(1, 2);
			n = $urandom_range(1, 8);
			repeat (n) push_byte(random_solid($urandom_range(0, 4) == 0));
		end
		// Damage: one byte replaced, or the line cut short.
		k = $urandom_range(0, 99);
		if (k < 15) begin
			line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (k < 25) begin
			n = $urandom_range(1, line_buf.size() - 1);
			while (line_buf.size() > n) void'(line_buf.pop_back());
		end
	endfunction

	function automatic void noise_line();
		int unsigned n;
		if ($urandom_range(0, 2) == 0) push_text("From ");
		n = $urandom_range(1, 40);
		repeat (n) push_byte(8'($urandom_range(0, 255)));
	endfunction

	// Sender: offers queued bytes, holding valid until each is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_valid <= 1'b0;
			up_data <= '0;
			idle_count = 0;
		end else begin
			if (up_valid && up_ready) begin
				envelope_predict(up_data);
				bytes_sent++;
			end
			if (!up_valid || up_ready) begin
				if (pending.size() == 0) begin
					up_valid <= 1'b0;
				end else if (pending[0].drain_first && verdicts_due.size() != 0) begin
					up_valid <= 1'b0;
				end else if (idle_count < pending[0].gap) begin
					idle_count++;
					up_valid <= 1'b0;
				end else begin
					up_data <= pending[0].req;
					up_valid <= 1'b1;
					void'(pending.pop_front());
					idle_count = 0;
				end
			end
		end
	end

	// Receiver: checks each verdict and stalls at random, twice for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_ready <= 1'b0;
			hold_left = 0;
			calm_left = 0;
		end else begin
			if (dn_valid && dn_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result with no request pending: is_envelope %0d address_offset %0d",
						dn_data.is_envelope, dn_data.address_offset);
					errors++;
				end else begin
					if (dn_data.is_envelope !== verdicts_due[0].is_envelope) begin
						$error("is_envelope: expected %0d, got %0d",
							verdicts_due[0].is_envelope, dn_data.is_envelope);
						errors++;
					end
					if (dn_data.address_offset !== verdicts_due[0].address_offset) begin
						$error("address_offset: expected %0d, got %0d",
							verdicts_due[0].address_offset, dn_data.address_offset);
						errors++;
					end
					void'(verdicts_due.pop_front());
				end
				verdicts_seen++;
				if (verdicts_seen == 12 || verdicts_seen == 30) hold_left = 400;
			end
			if (hold_left == 0 && calm_left == 0) begin
				case ($urandom_range(0, 99)) inside
					[0:2]: calm_left = $urandom_range(50, 150);
					[3:14]: hold_left = $urandom_range(1, 4);
					[15:17]: hold_left = $urandom_range(10, 60);
					default: ;
				endcase
			end
			if (hold_left != 0) begin
				hold_left--;
				dn_ready <= 1'b0;
			end else begin
				if (calm_left != 0) calm_left--;
				dn_ready <= 1'b1;
			end
		end
	end

	// Cycles since the last handshake on either channel.
	always @(posedge clk) begin
		if ((up_valid && up_ready) || (dn_valid && dn_ready)) quiet = 0;
		else quiet++;
	end

	initial begin
		int unsigned random_lines;
		line_restart();

		// Well-formed envelopes: plain, escaped, tabs and mixed case, colon only in the tail.
		push_text("From user@host Sat Jan  3 12:34:56 2004");
		close_line(1'b0);
		push_text(">From a Mon FEB 9 1:00:00");
		close_line(1'b0);
		push_text("From \tx\t sUn\tdEc\t31 1234\tremote:here");
		close_line(1'b0);
		// No colon at all.
		push_text("From bob Tue Mar 01 0000 2020");
		close_line(1'b1);
		// Short lines: inside the leader, single bytes, and a time token cut at three.
		push_text("Fro");
		close_line(1'b0);
		push_byte(mel_pkg::CH_UPPER_F);
		close_line(1'b0);
		push_byte(8'hFF);
		close_line(1'b0);
		push_byte(mel_pkg::CH_ESCAPE);
		close_line(1'b0);
		push_text("From a Wed Apr 5 1:2");
		close_line(1'b0);
		// Address that starts with a colon.
		push_text("From :x Thu May 10 10:00:00");
		close_line(1'b0);
		// Zero and all-ones bytes as ordinary address characters.
		push_text("From ");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_text(" Fri Jun 07 00:00");
		close_line(1'b0);
		// Bad tokens: long weekday, three-digit day, time not starting with a digit.
		push_text("From a Mond Jul 1 10:00");
		close_line(1'b0);
		push_text("From a Sat Aug 123 10:00");
		close_line(1'b0);
		push_text("From a Sat Sep 12 x0:00");
		close_line(1'b0);
		// Double escape, misspelled leader, and a tab in place of the leader space.
		push_text(">>From a Sun Jan 1 10:00");
		close_line(1'b0);
		push_text("Frum a Sun Jan 1 10:00");
		close_line(1'b0);
		push_text("From\ta Sun Jan 1 10:00");
		close_line(1'b0);
		// Far address: the first position past the line limit is rejected.
		push_text("From ");
		push_blanks(LINE_CAP - 5, LINE_CAP - 5);
		push_text("x Wed Aug 15 10:00");
		close_line(1'b1);

		// Random part: mostly envelope-shaped lines, the rest noise.
		random_lines = 0;
		while (pending.size() < ITEM_TARGET || random_lines < RANDOM_LINES) begin
			if ($urandom_range(0, 9) < 8) random_envelope();
			else noise_line();
			close_line(random_lines % 10 == 9);
			random_lines++;
		end
		total_bytes = pending.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while ((bytes_sent < total_bytes || verdicts_due.size() != 0) && quiet < QUIET_LIMIT)
			@(posedge clk);
		if (quiet < QUIET_LIMIT) repeat (DRAIN_CYCLES) @(posedge clk);
		if (quiet >= QUIET_LIMIT) begin
			$error("no handshake for %0d cycles", QUIET_LIMIT);
			errors++;
		end
		if (verdicts_due.size() != 0) begin
			$error("%0d verdicts never arrived", verdicts_due.size());
			errors++;
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/mel_pkg.sv
rtl/core/mel_parse.sv
rtl/core/mail_envelope_line_matcher.sv
dv/mail_envelope_line_matcher_tb.sv
